[hdl/eyvm_pkg.sv]
// ----------------------------------------------------------------------------
// eyvm_pkg
// Shared constants, types and fixed-point helpers of the Y-X-Z view matrix.
// ----------------------------------------------------------------------------
package eyvm_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned ANGLE_W        = 16;
  localparam int unsigned PHASE_W        = 16;
  localparam int unsigned AXIS_W         = 16;
  localparam int unsigned POS_W          = 32;
  localparam int unsigned SINE_LAT       = 5;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'd16384;
  localparam logic [PHASE_W-1:0] THREE_QUART  = 16'd49152;

  localparam logic [13:0] SIN_B = 14'd10512;
  localparam logic [14:0] SIN_A = 15'd25736;
  localparam logic [10:0] SIN_C = 11'd1160;

  typedef logic signed [AXIS_W-1:0] q14_t;
  typedef logic [PHASE_W-1:0]       phase_t;

  // Q1.14 product rounded half up
  function automatic q14_t qmul(input q14_t a, input q14_t b);
    logic signed [31:0] p;
    logic signed [31:0] r;
    begin
      p = a * b;
      r = (p + 32'sd8192) >>> 14;
      return r[AXIS_W-1:0];
    end
  endfunction

  // clamp a sum of products to +-1.0
  function automatic q14_t clamp_axis(input logic signed [17:0] v);
    begin
      if (v > 18'sd16384) begin
        return 16'sd16384;
      end else if (v < -18'sd16384) begin
        return -16'sd16384;
      end else begin
        return v[AXIS_W-1:0];
      end
    end
  endfunction

endpackage

[hdl/eyvm_sine.sv]
// ----------------------------------------------------------------------------
// eyvm_sine
// Five-stage Q1.14 sine of a 16-bit binary angle by an odd polynomial.
// ----------------------------------------------------------------------------
module eyvm_sine
  import eyvm_pkg::*;
(
  input  logic   clk_i,
  input  phase_t phase_i,
  output q14_t   sine_o
);

  logic signed [17:0] z;
  logic [14:0] a_d;

  logic [14:0] a1_q, a2_q, a3_q, a4_q;
  logic        neg1_q, neg2_q, neg3_q, neg4_q;
  logic [14:0] sq2_q, sq3_q;
  logic [13:0] t1_q;
  logic [14:0] t2_q;
  q14_t        sine_q;

  logic [29:0] sq_prod;
  logic [25:0] c_prod;
  logic [28:0] t_prod;
  logic [29:0] s_prod;
  logic [16:0] s_ext;

  // fold into [-quarter, quarter]
  always_comb begin
    if (phase_i < QUARTER_TURN) begin
      z = $signed({2'b00, phase_i});
    end else if (phase_i < THREE_QUART) begin
      z = 18'sd32768 - $signed({2'b00, phase_i});
    end else begin
      z = $signed({2'b00, phase_i}) - 18'sd65536;
    end
    a_d = z[17] ? 15'(-z) : z[14:0];
  end

  assign sq_prod = a1_q * a1_q;
  assign c_prod  = sq2_q * SIN_C;
  assign t_prod  = sq3_q * t1_q;
  assign s_prod  = a4_q * t2_q;
  assign s_ext   = {1'b0, s_prod[29:14]};

  always_ff @(posedge clk_i) begin
    a1_q   <= a_d;
    neg1_q <= z[17];
    sq2_q  <= sq_prod[28:14];
    a2_q   <= a1_q;
    neg2_q <= neg1_q;
    t1_q   <= SIN_B - 14'(c_prod[25:14]);
    sq3_q  <= sq2_q;
    a3_q   <= a2_q;
    neg3_q <= neg2_q;
    t2_q   <= SIN_A - t_prod[28:14];
    a4_q   <= a3_q;
    neg4_q <= neg3_q;
    sine_q <= neg4_q ? q14_t'(-s_ext) : q14_t'(s_ext);
  end

  assign sine_o = sine_q;

endmodule

[hdl/euler_yxz_view_matrix.sv]
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix
// Fixed-point view matrix from a camera position and Y-X-Z Euler angles.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pos_*_i (signed Q16.16) and angle_*_i (binary angles, a full turn
//   is 2^ANGLE_BITS) and pulse start_i. busy_o stays low: a transfer is
//   taken at every edge with start_i high, one pose per cycle.
//   After a transfer, valid_o is high for one cycle with
//   the right, up and forward axes (Q1.14, clamped to +-1.0) and the
//   translation shift_u/v/w (saturated). The last matrix row 0,0,0,1 is not
//   output.
//   Pipeline: five stages of sine polynomial (six units in parallel for the
//   sine and cosine of each angle), two stages of Q1.14 products, one of
//   sums and clamps, one of axis-by-position products, one three-way sum
//   and one round-and-saturate stage. Latency is fixed by this chain.
//   Reset clears only the valid bits; items in flight are dropped. The
//   receiver cannot stall: every result is presented for one cycle only.
// ----------------------------------------------------------------------------
module euler_yxz_view_matrix
  import eyvm_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  input  logic [ANGLE_W-1:0]       angle_x_i,
  input  logic [ANGLE_W-1:0]       angle_y_i,
  input  logic [ANGLE_W-1:0]       angle_z_i,
  output logic                     valid_o,
  output q14_t                     right_x_o,
  output q14_t                     right_y_o,
  output q14_t                     right_z_o,
  output q14_t                     up_x_o,
  output q14_t                     up_y_o,
  output q14_t                     up_z_o,
  output q14_t                     fwd_x_o,
  output q14_t                     fwd_y_o,
  output q14_t                     fwd_z_o,
  output logic signed [POS_W-1:0]  shift_u_o,
  output logic signed [POS_W-1:0]  shift_v_o,
  output logic signed [POS_W-1:0]  shift_w_o
);

  localparam int unsigned LAT = SINE_LAT + 6;
  localparam int unsigned POS_DLY = SINE_LAT + 3;
  localparam logic [ANGLE_W-1:0] AngleMask =
      (ANGLE_BITS >= ANGLE_W) ? {ANGLE_W{1'b1}} : ANGLE_W'((1 << ANGLE_BITS) - 1);

  // angle to 16-bit phase, dropping bits above ANGLE_BITS
  function automatic phase_t phase_of(input logic [ANGLE_W-1:0] ang);
    logic [31:0] ph;
    begin
      ph = {16'd0, ang & AngleMask} << (32 - ANGLE_BITS);
      return ph[31:16];
    end
  endfunction

  logic   accept;
  logic [LAT-1:0] valid_q;
  phase_t ph_x, ph_y, ph_z;
  q14_t   s_x, c_x, s_y, c_y, s_z, c_z;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign ph_x = phase_of(angle_x_i);
  assign ph_y = phase_of(angle_y_i);
  assign ph_z = phase_of(angle_z_i);

  eyvm_sine u_sin_x (.clk_i, .phase_i(ph_x),                .sine_o(s_x));
  eyvm_sine u_cos_x (.clk_i, .phase_i(ph_x + QUARTER_TURN), .sine_o(c_x));
  eyvm_sine u_sin_y (.clk_i, .phase_i(ph_y),                .sine_o(s_y));
  eyvm_sine u_cos_y (.clk_i, .phase_i(ph_y + QUARTER_TURN), .sine_o(c_y));
  eyvm_sine u_sin_z (.clk_i, .phase_i(ph_z),                .sine_o(s_z));
  eyvm_sine u_cos_z (.clk_i, .phase_i(ph_z + QUARTER_TURN), .sine_o(c_z));

  // advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], accept};
    end
  end

  // hold the position until the axes are ready
  logic signed [POS_W-1:0] px_q [POS_DLY];
  logic signed [POS_W-1:0] py_q [POS_DLY];
  logic signed [POS_W-1:0] pz_q [POS_DLY];

  always_ff @(posedge clk_i) begin
    px_q[0] <= pos_x_i;
    py_q[0] <= pos_y_i;
    pz_q[0] <= pos_z_i;
    for (int i = 1; i < POS_DLY; i++) begin
      px_q[i] <= px_q[i-1];
      py_q[i] <= py_q[i-1];
      pz_q[i] <= pz_q[i-1];
    end
  end

  // first products
  q14_t cycz_q, sysx_q, cysx_q, czsy_q, cxsz_q, cysz_q, cxcz_q, sysz_q, cxsy_q, cycx_q;
  q14_t sz6_q, sx6_q;
  // second products
  q14_t sysxsz_q, cysxsz_q, czsysx_q, cyczsx_q;
  q14_t cycz7_q, czsy7_q, cysz7_q, sysz7_q, cxsz7_q, cxcz7_q, cxsy7_q, cycx7_q, sx7_q;

  always_ff @(posedge clk_i) begin
    cycz_q   <= qmul(c_y, c_z);
    sysx_q   <= qmul(s_y, s_x);
    cysx_q   <= qmul(c_y, s_x);
    czsy_q   <= qmul(c_z, s_y);
    cxsz_q   <= qmul(c_x, s_z);
    cysz_q   <= qmul(c_y, s_z);
    cxcz_q   <= qmul(c_x, c_z);
    sysz_q   <= qmul(s_y, s_z);
    cxsy_q   <= qmul(c_x, s_y);
    cycx_q   <= qmul(c_y, c_x);
    sz6_q    <= s_z;
    sx6_q    <= s_x;

    sysxsz_q <= qmul(sysx_q, sz6_q);
    cysxsz_q <= qmul(cysx_q, sz6_q);
    czsysx_q <= qmul(czsy_q, sx6_q);
    cyczsx_q <= qmul(cycz_q, sx6_q);
    cycz7_q  <= cycz_q;
    czsy7_q  <= czsy_q;
    cysz7_q  <= cysz_q;
    sysz7_q  <= sysz_q;
    cxsz7_q  <= cxsz_q;
    cxcz7_q  <= cxcz_q;
    cxsy7_q  <= cxsy_q;
    cycx7_q  <= cycx_q;
    sx7_q    <= sx6_q;
  end

  // sums and clamps
  q14_t ax_q [9];

  always_ff @(posedge clk_i) begin
    ax_q[0] <= clamp_axis(18'(cycz7_q) + 18'(sysxsz_q));
    ax_q[1] <= clamp_axis(18'(cxsz7_q));
    ax_q[2] <= clamp_axis(18'(cysxsz_q) - 18'(czsy7_q));
    ax_q[3] <= clamp_axis(18'(czsysx_q) - 18'(cysz7_q));
    ax_q[4] <= clamp_axis(18'(cxcz7_q));
    ax_q[5] <= clamp_axis(18'(cyczsx_q) + 18'(sysz7_q));
    ax_q[6] <= clamp_axis(18'(cxsy7_q));
    ax_q[7] <= clamp_axis(-18'(sx7_q));
    ax_q[8] <= clamp_axis(18'(cycx7_q));
  end

  // translation: products, negated sum, round and saturate
  logic signed [47:0] prod_q [9];
  logic signed [50:0] neg_q [3];
  q14_t ax9_q [9];
  q14_t ax10_q [9];
  q14_t ax11_q [9];
  logic signed [POS_W-1:0] shift_q [3];
  logic signed [50:0] sum_d [3];
  logic signed [50:0] rnd_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = 51'(prod_q[3*k]) + 51'(prod_q[3*k+1]) + 51'(prod_q[3*k+2]);
      rnd_d[k] = (neg_q[k] + 51'sd8192) >>> 14;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[3*k]   <= ax_q[3*k]   * px_q[POS_DLY-1];
      prod_q[3*k+1] <= ax_q[3*k+1] * py_q[POS_DLY-1];
      prod_q[3*k+2] <= ax_q[3*k+2] * pz_q[POS_DLY-1];
      neg_q[k]      <= -sum_d[k];
      if (rnd_d[k] > 51'sd2147483647) begin
        shift_q[k] <= 32'sh7FFFFFFF;
      end else if (rnd_d[k] < -51'sd2147483648) begin
        shift_q[k] <= 32'sh80000000;
      end else begin
        shift_q[k] <= rnd_d[k][POS_W-1:0];
      end
    end
    ax9_q  <= ax_q;
    ax10_q <= ax9_q;
    ax11_q <= ax10_q;
  end

  assign valid_o   = valid_q[LAT-1];
  assign right_x_o = ax11_q[0];
  assign right_y_o = ax11_q[1];
  assign right_z_o = ax11_q[2];
  assign up_x_o    = ax11_q[3];
  assign up_y_o    = ax11_q[4];
  assign up_z_o    = ax11_q[5];
  assign fwd_x_o   = ax11_q[6];
  assign fwd_y_o   = ax11_q[7];
  assign fwd_z_o   = ax11_q[8];
  assign shift_u_o = shift_q[0];
  assign shift_v_o = shift_q[1];
  assign shift_w_o = shift_q[2];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT valid_o)
    else $error("result strobe missing after a transfer");

  a_right_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (right_x_o <= 16'sd16384 && right_x_o >= -16'sd16384))
    else $error("right axis out of range");

  a_fwd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (fwd_z_o <= 16'sd16384 && fwd_z_o >= -16'sd16384 &&
                 up_y_o <= 16'sd16384 && up_y_o >= -16'sd16384))
    else $error("forward or up axis out of range");

endmodule
